// ===== sv/voxel_face_cull_mesher_assert.svh =====
// Assertion macros for the voxel face culling mesher.
`ifndef VOXEL_FACE_CULL_MESHER_ASSERT_SVH
`define VOXEL_FACE_CULL_MESHER_ASSERT_SVH
`ifndef SYNTHESIS
`define VFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vfc: same-cycle check failed");
`define VFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vfc: next-cycle check failed");
`else
`define VFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define VFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/vfc_pkg.sv =====
`default_nettype none
package vfc_pkg;

  localparam int SIZE_X_DEF = 16;
  localparam int SIZE_Y_DEF = 64;
  localparam int SIZE_Z_DEF = 16;

  localparam int COORD_W = 10;
  localparam int VOXEL_W = 8;
  localparam int VCNT_W  = 19;
  localparam logic [VCNT_W-1:0] VCNT_CAP = 19'd524284;
  localparam logic [VCNT_W-1:0] VCNT_STEP = 19'd4;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_BEGIN = 2'd1;
  localparam logic [1:0] CMD_MESH  = 2'd2;

  localparam logic [2:0] FACE_TOP    = 3'd0;
  localparam logic [2:0] FACE_BOTTOM = 3'd1;
  localparam logic [2:0] FACE_PX     = 3'd2;
  localparam logic [2:0] FACE_NX     = 3'd3;
  localparam logic [2:0] FACE_PZ     = 3'd4;
  localparam logic [2:0] FACE_NZ     = 3'd5;

  localparam logic [1:0] ROW_LOWER = 2'd0;
  localparam logic [1:0] ROW_UPPER = 2'd1;
  localparam logic [1:0] ROW_OTHER = 2'd2;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRASS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STONE = 1'b1;

  typedef enum logic [1:0] {
    LOC_NONE  = 2'd0,
    LOC_VOL   = 2'd1,
    LOC_SHELL = 2'd2
  } loc_kind_t;

  typedef struct packed {
    logic                 wr_en;
    loc_kind_t            kind;
    logic [VOXEL_W-1:0]   data;
  } vfc_req_t;

endpackage
`default_nettype wire

// ===== sv/vfc_locate.sv =====
`default_nettype none
module vfc_locate import vfc_pkg::*; #(
  parameter int SIZE_X = SIZE_X_DEF,
  parameter int SIZE_Y = SIZE_Y_DEF,
  parameter int SIZE_Z = SIZE_Z_DEF,
  localparam int VOL_CELLS = SIZE_X * SIZE_Y * SIZE_Z,
  localparam int PLANE_XZ = SIZE_X * SIZE_Z,
  localparam int PLANE_YZ = SIZE_Y * SIZE_Z,
  localparam int PLANE_YX = SIZE_Y * SIZE_X,
  localparam int SHELL_CELLS = 2 * (PLANE_XZ + PLANE_YZ + PLANE_YX),
  localparam int VA_W = $clog2(VOL_CELLS),
  localparam int SA_W = $clog2(SHELL_CELLS)
) (
  input  logic signed [COORD_W-1:0] x,
  input  logic signed [COORD_W-1:0] y,
  input  logic signed [COORD_W-1:0] z,
  output loc_kind_t                 kind,
  output logic [VA_W-1:0]           vol_addr,
  output logic [SA_W-1:0]           shell_addr
);

  localparam logic signed [COORD_W-1:0] ZERO_S = '0;
  localparam logic signed [COORD_W-1:0] M1_S = '1;
  localparam logic signed [COORD_W-1:0] SX_S = COORD_W'(SIZE_X);
  localparam logic signed [COORD_W-1:0] SY_S = COORD_W'(SIZE_Y);
  localparam logic signed [COORD_W-1:0] SZ_S = COORD_W'(SIZE_Z);

  logic ix, iy, iz;
  logic xe, ye, ze;
  logic [31:0] xu, yu, zu;
  logic [31:0] vol_sum, shell_sum;

  assign ix = (x >= ZERO_S) && (x < SX_S);
  assign iy = (y >= ZERO_S) && (y < SY_S);
  assign iz = (z >= ZERO_S) && (z < SZ_S);
  assign xe = (x == SX_S) || (x == M1_S);
  assign ye = (y == SY_S) || (y == M1_S);
  assign ze = (z == SZ_S) || (z == M1_S);
  assign xu = 32'($unsigned(x));
  assign yu = 32'($unsigned(y));
  assign zu = 32'($unsigned(z));

  assign vol_sum = xu + zu * 32'(SIZE_X) + yu * 32'(PLANE_XZ);

  always_comb begin
    kind = LOC_NONE;
    shell_sum = '0;
    if (ix && iy && iz) begin
      kind = LOC_VOL;
    end else if (ix && iz && ye) begin
      kind = LOC_SHELL;
      shell_sum = ((y == SY_S) ? 32'd0 : 32'(PLANE_XZ)) + xu + zu * 32'(SIZE_X);
    end else if (iy && iz && xe) begin
      kind = LOC_SHELL;
      shell_sum = 32'(2 * PLANE_XZ) + ((x == SX_S) ? 32'd0 : 32'(PLANE_YZ))
                  + yu * 32'(SIZE_Z) + zu;
    end else if (iy && ix && ze) begin
      kind = LOC_SHELL;
      shell_sum = 32'(2 * PLANE_XZ + 2 * PLANE_YZ)
                  + ((z == SZ_S) ? 32'd0 : 32'(PLANE_YX)) + yu * 32'(SIZE_X) + xu;
    end
  end

  assign vol_addr = vol_sum[VA_W-1:0];
  assign shell_addr = shell_sum[SA_W-1:0];

endmodule
`default_nettype wire

// ===== sv/vfc_store.sv =====
`default_nettype none
module vfc_store import vfc_pkg::*; #(
  parameter int SIZE_X = SIZE_X_DEF,
  parameter int SIZE_Y = SIZE_Y_DEF,
  parameter int SIZE_Z = SIZE_Z_DEF,
  localparam int VOL_CELLS = SIZE_X * SIZE_Y * SIZE_Z,
  localparam int SHELL_CELLS = 2 * (SIZE_X * SIZE_Z + SIZE_Y * SIZE_Z + SIZE_Y * SIZE_X),
  localparam int VA_W = $clog2(VOL_CELLS),
  localparam int SA_W = $clog2(SHELL_CELLS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vfc_req_t           req,
  input  logic [VA_W-1:0]    vol_addr,
  input  logic [SA_W-1:0]    shell_addr,
  output logic [VOXEL_W-1:0] rd_data,
  output logic               clr_done
);

  localparam int MAX_D = (VOL_CELLS > SHELL_CELLS) ? VOL_CELLS : SHELL_CELLS;
  localparam int CL_W = $clog2(MAX_D);

  logic [VOXEL_W-1:0] voxel_mem [VOL_CELLS];
  logic [VOXEL_W-1:0] border_mem [SHELL_CELLS];
  logic [VOXEL_W-1:0] vox_rd_r, bor_rd_r;
  loc_kind_t          rd_kind_r;
  logic               clr_act_r, clr_act_nxt;
  logic [CL_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic               clr_vol, clr_bor;

  assign clr_vol = clr_act_r && ({1'b0, clr_cnt_r} < (CL_W+1)'(VOL_CELLS));
  assign clr_bor = clr_act_r && ({1'b0, clr_cnt_r} < (CL_W+1)'(SHELL_CELLS));

  always_comb begin
    clr_act_nxt = clr_act_r;
    clr_cnt_nxt = clr_cnt_r;
    if (clr_act_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == CL_W'(MAX_D - 1)) begin
        clr_act_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_act_r <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      clr_act_r <= clr_act_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_vol) begin
      voxel_mem[clr_cnt_r[VA_W-1:0]] <= '0;
    end else if (req.wr_en && req.kind == LOC_VOL) begin
      voxel_mem[vol_addr] <= req.data;
    end
    vox_rd_r <= voxel_mem[vol_addr];
  end

  always_ff @(posedge clk) begin
    if (clr_bor) begin
      border_mem[clr_cnt_r[SA_W-1:0]] <= '0;
    end else if (req.wr_en && req.kind == LOC_SHELL) begin
      border_mem[shell_addr] <= req.data;
    end
    bor_rd_r <= border_mem[shell_addr];
  end

  always_ff @(posedge clk) begin
    rd_kind_r <= req.kind;
  end

  always_comb begin
    case (rd_kind_r)
      LOC_VOL:   rd_data = vox_rd_r;
      LOC_SHELL: rd_data = bor_rd_r;
      default:   rd_data = '0;
    endcase
  end

  assign clr_done = !clr_act_r;

endmodule
`default_nettype wire

// ===== sv/voxel_face_cull_mesher.sv =====
// Write and begin commands leave busy low.
// Mesh cell: busy goes high after start while the cell emits n faces (n = 0..6):
// seven reads through the single store port in ST_READ, a decision in ST_LAST, then the faces in ST_EMIT.
// Faces appear one per cycle on out_valid, registered from ST_EMIT.
// After reset a clearing pass walks max(volume, shell) addresses and zeroes the stores
// (16384 addresses at default size) with busy high; configuration writes are taken meanwhile.
`default_nettype none
`include "voxel_face_cull_mesher_assert.svh"
module voxel_face_cull_mesher import vfc_pkg::*; #(
  parameter int SIZE_X = SIZE_X_DEF,
  parameter int SIZE_Y = SIZE_Y_DEF,
  parameter int SIZE_Z = SIZE_Z_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_cmd,
  input  logic signed [5:0]    in_pos_x,
  input  logic signed [7:0]    in_pos_y,
  input  logic signed [5:0]    in_pos_z,
  input  logic [7:0]           in_block_value,
  output logic                 out_valid,
  output logic [2:0]           out_face,
  output logic [3:0]           out_cell_x,
  output logic [5:0]           out_cell_y,
  output logic [3:0]           out_cell_z,
  output logic [1:0]           out_texture_row,
  output logic [VCNT_W-1:0]    out_first_vertex,
  output logic                 out_last_face,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [7:0]           cfg_wdata
);

  localparam int VOL_CELLS = SIZE_X * SIZE_Y * SIZE_Z;
  localparam int SHELL_CELLS = 2 * (SIZE_X * SIZE_Z + SIZE_Y * SIZE_Z + SIZE_Y * SIZE_X);
  localparam int VA_W = $clog2(VOL_CELLS);
  localparam int SA_W = $clog2(SHELL_CELLS);
  localparam logic [2:0] RD_LAST = 3'd6;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_LAST  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic signed [COORD_W-1:0] cx_r, cy_r, cz_r, cx_nxt, cy_nxt, cz_nxt;
  logic [2:0]         rd_idx_r, rd_idx_nxt;
  logic [5:0]         mask_r, mask_nxt;
  logic               ctr_nz_r, ctr_nz_nxt;
  logic [VOXEL_W-1:0] ctr_id_r, ctr_id_nxt;
  logic [VCNT_W-1:0]  vcnt_r, vcnt_nxt;
  logic               ov_r, ov_nxt;
  logic [2:0]         of_r, of_nxt;
  logic [1:0]         orow_r, orow_nxt;
  logic [VCNT_W-1:0]  ofv_r, ofv_nxt;
  logic               olast_r, olast_nxt;
  logic [7:0]         grass_r, stone_r;

  logic signed [COORD_W-1:0] ex_x, ex_y, ex_z, lx, ly, lz, dx, dy, dz;
  logic [2:0]         face_sel;
  loc_kind_t          loc_kind;
  logic [VA_W-1:0]    vol_addr;
  logic [SA_W-1:0]    shell_addr;
  logic [VOXEL_W-1:0] rd_data;
  logic               clr_done;
  vfc_req_t           req;
  logic [2:0]         pick;
  logic [5:0]         pick_bit, mask_full;
  logic [1:0]         row;

  assign ex_x = COORD_W'(in_pos_x);
  assign ex_y = COORD_W'(in_pos_y);
  assign ex_z = COORD_W'(in_pos_z);

  assign face_sel = rd_idx_r - 3'd1;

  always_comb begin
    dx = '0;
    dy = '0;
    dz = '0;
    case (face_sel)
      FACE_TOP:    dy = COORD_W'(1);
      FACE_BOTTOM: dy = '1;
      FACE_PX:     dx = COORD_W'(1);
      FACE_NX:     dx = '1;
      FACE_PZ:     dz = COORD_W'(1);
      FACE_NZ:     dz = '1;
      default:     ;
    endcase
  end

  assign lx = (state_r == ST_IDLE) ? ex_x : cx_r + dx;
  assign ly = (state_r == ST_IDLE) ? ex_y : cy_r + dy;
  assign lz = (state_r == ST_IDLE) ? ex_z : cz_r + dz;

  vfc_locate #(.SIZE_X(SIZE_X), .SIZE_Y(SIZE_Y), .SIZE_Z(SIZE_Z)) u_locate (
    .x          (lx),
    .y          (ly),
    .z          (lz),
    .kind       (loc_kind),
    .vol_addr   (vol_addr),
    .shell_addr (shell_addr)
  );

  assign req.wr_en = (state_r == ST_IDLE) && start && (in_cmd == CMD_WRITE);
  assign req.kind  = loc_kind;
  assign req.data  = in_block_value;

  vfc_store #(.SIZE_X(SIZE_X), .SIZE_Y(SIZE_Y), .SIZE_Z(SIZE_Z)) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .vol_addr   (vol_addr),
    .shell_addr (shell_addr),
    .rd_data    (rd_data),
    .clr_done   (clr_done)
  );

  always_comb begin
    pick = 3'd0;
    for (int f = 5; f >= 0; f--) begin
      if (mask_r[f]) begin
        pick = 3'(f);
      end
    end
  end

  assign pick_bit = 6'd1 << pick;
  assign mask_full = {(rd_data == '0), mask_r[4:0]};

  always_comb begin
    if (ctr_id_r == grass_r) begin
      row = ROW_UPPER;
    end else if (ctr_id_r == stone_r) begin
      row = ROW_LOWER;
    end else begin
      row = ROW_OTHER;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    cz_nxt     = cz_r;
    rd_idx_nxt = rd_idx_r;
    mask_nxt   = mask_r;
    ctr_nz_nxt = ctr_nz_r;
    ctr_id_nxt = ctr_id_r;
    vcnt_nxt   = vcnt_r;
    ov_nxt     = 1'b0;
    of_nxt     = of_r;
    orow_nxt   = orow_r;
    ofv_nxt    = ofv_r;
    olast_nxt  = olast_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (in_cmd)
            CMD_BEGIN: vcnt_nxt = '0;
            CMD_MESH: begin
              if (loc_kind == LOC_VOL) begin
                cx_nxt     = ex_x;
                cy_nxt     = ex_y;
                cz_nxt     = ex_z;
                rd_idx_nxt = '0;
                mask_nxt   = '0;
                state_nxt  = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        rd_idx_nxt = rd_idx_r + 3'd1;
        if (rd_idx_r == 3'd1) begin
          ctr_nz_nxt = (rd_data != '0);
          ctr_id_nxt = rd_data;
        end else if (rd_idx_r >= 3'd2) begin
          mask_nxt[3'(rd_idx_r - 3'd2)] = (rd_data == '0);
        end
        if (rd_idx_r == RD_LAST) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        mask_nxt = mask_full;
        if (ctr_nz_r && (mask_full != '0)) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        ov_nxt    = 1'b1;
        of_nxt    = pick;
        orow_nxt  = row;
        ofv_nxt   = vcnt_r;
        olast_nxt = ((mask_r & ~pick_bit) == '0);
        mask_nxt  = mask_r & ~pick_bit;
        vcnt_nxt  = (vcnt_r >= VCNT_CAP) ? VCNT_CAP : vcnt_r + VCNT_STEP;
        if ((mask_r & ~pick_bit) == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      vcnt_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vcnt_r  <= vcnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    cz_r     <= cz_nxt;
    rd_idx_r <= rd_idx_nxt;
    mask_r   <= mask_nxt;
    ctr_nz_r <= ctr_nz_nxt;
    ctr_id_r <= ctr_id_nxt;
    of_r     <= of_nxt;
    orow_r   <= orow_nxt;
    ofv_r    <= ofv_nxt;
    olast_r  <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grass_r <= 8'd1;
      stone_r <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_GRASS: grass_r <= cfg_wdata;
        CFG_STONE: stone_r <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = ov_r;
  assign out_face         = of_r;
  assign out_cell_x       = cx_r[3:0];
  assign out_cell_y       = cy_r[5:0];
  assign out_cell_z       = cz_r[3:0];
  assign out_texture_row  = orow_r;
  assign out_first_vertex = ofv_r;
  assign out_last_face    = olast_r;

  `VFC_ASSERT_NXT(a_faces_run, clk, rst_n, ov_r && !olast_r, ov_r)
  `VFC_ASSERT_NXT(a_mesh_start_quiet, clk, rst_n, start && !busy && in_cmd == CMD_MESH, !ov_r)
  `VFC_ASSERT_IMP(a_vertex_aligned, clk, rst_n, ov_r, ofv_r[1:0] == 2'b00)
  `VFC_ASSERT_IMP(a_emit_has_face, clk, rst_n, state_r == ST_EMIT, mask_r != '0)
  `VFC_ASSERT_IMP(a_clear_quiet, clk, rst_n, state_r == ST_CLEAR, !ov_r && busy)

endmodule
`default_nettype wire
